// File: design/i2cms_pkg.sv
// shared types and constants of the i2c master bit sequencer
package i2cms_pkg;

    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int HOLD_W   = 7;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 5;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    localparam logic [BYTE_W-1:0] READ_BIT = 8'h01;

    localparam logic [HOLD_W-1:0] HOLD_NONE  = 7'd0;
    localparam logic [HOLD_W-1:0] HOLD_SETUP = 7'(40 / 2);
    localparam logic [HOLD_W-1:0] HOLD_LONG  = 7'(200 / 2);
    localparam logic [HOLD_W-1:0] HOLD_MID   = 7'(80 / 2);
    localparam logic [HOLD_W-1:0] HOLD_HIGH  = 7'(160 / 2);
    localparam logic [HOLD_W-1:0] HOLD_RXLOW = 7'(120 / 2);

    localparam logic [STEP_W-1:0] STEP_FIRST     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SECOND    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ACK_LOW   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ACK_HIGH  = 5'd17;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ACK  = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_SEND  = 3'd2,
        OP_RECV  = 3'd3,
        OP_ACK   = 3'd4,
        OP_NAK   = 3'd5,
        OP_PROBE = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        SEG_START,
        SEG_STOP,
        SEG_SEND,
        SEG_RECV,
        SEG_ACKBIT
    } t_seg;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] tx_byte;
        logic              bus_free;
        logic              nak;
        logic [BYTE_W-1:0] rx_bits;
    } t_desc;

endpackage

// File: design/i2cms_cmd_if.sv
// command channel of the i2c master bit sequencer
interface i2cms_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [i2cms_pkg::MODE_W-1:0]   mode;
    logic [i2cms_pkg::BYTE_W-1:0]   tx_byte;
    logic                           sda_sense;
    logic                           scl_sense;
    logic                           ack_sense;
    logic [i2cms_pkg::BYTE_W-1:0]   rx_bits;

    modport source (output valid, mode, tx_byte, sda_sense, scl_sense, ack_sense, rx_bits,
                    input ready);
    modport sink (input valid, mode, tx_byte, sda_sense, scl_sense, ack_sense, rx_bits,
                  output ready);
endinterface

// File: design/i2cms_phase_if.sv
// bus phase channel of the i2c master bit sequencer
interface i2cms_phase_if;
    logic                           valid;
    logic                           ready;
    logic                           scl_level;
    logic                           sda_level;
    logic                           sda_enable;
    logic [i2cms_pkg::HOLD_W-1:0]   hold_ticks;
    logic [i2cms_pkg::STATUS_W-1:0] status;
    logic [i2cms_pkg::BYTE_W-1:0]   rx_data;
    logic                           last;

    modport source (output valid, scl_level, sda_level, sda_enable, hold_ticks, status,
                    rx_data, last, input ready);
    modport sink (input valid, scl_level, sda_level, sda_enable, hold_ticks, status,
                  rx_data, last, output ready);
endinterface

// File: design/i2c_master_bit_sequencer_core.sv
// top level of the i2c master bit sequencer
//
//  channel   dir  handshake          beat
//  i_cmd     in   valid/ready        one command: mode, tx_byte, senses, rx_bits
//  o_phase   out  valid/ready        one bus phase: levels, hold, status, rx_data, last
//
// a command gives 1 to 25 phase beats, one per cycle while the output does not stall; the
// phase sequencer steps one segment position per beat, and a queued next command
// follows without a gap
// commands enter the queue while the sequencer works; mode seven is taken and dropped
// output stalls freeze the sequencer; the queue keeps taking commands until full
// reset puts scl, sda and drive high and empties the queue, no clearing pass
module i2c_master_bit_sequencer_core #(
    parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cms_cmd_if.sink       i_cmd,
    i2cms_phase_if.source   o_phase
);
    import i2cms_pkg::*;

    logic   push, q_full, q_valid, q_pop;
    t_desc  front_desc, q_desc;

    i2cms_front u_front (
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (front_desc)
    );

    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (q_pop)
    );

    i2cms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_q_pop   (q_pop),
        .o_phase   (o_phase)
    );

`ifndef SYNTHESIS
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_phase.valid && (o_phase.status != ST_OK)) |-> o_phase.last)
        else $error("status reported before final phase");

    a_rx_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_phase.valid && (o_phase.rx_data != '0)) |-> o_phase.last)
        else $error("received byte reported before final phase");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_phase.valid)
        else $error("phase beat right after reset");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif
endmodule

// File: design/i2cms_front.sv
// command intake: decodes and classifies each command beat
module i2cms_front (
    i2cms_cmd_if.sink          i_cmd,
    input  logic               i_q_full,
    output logic               o_push,
    output i2cms_pkg::t_desc   o_desc
);
    import i2cms_pkg::*;

    logic is_probe;

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full && (i_cmd.mode != MODE_UNUSED);
    assign is_probe    = (i_cmd.mode == OP_PROBE);

    always_comb begin
        o_desc.op       = t_op'(i_cmd.mode);
        o_desc.tx_byte  = is_probe ? (i_cmd.tx_byte | READ_BIT) : i_cmd.tx_byte;
        o_desc.bus_free = i_cmd.sda_sense && i_cmd.scl_sense;
        o_desc.nak      = i_cmd.ack_sense;
        o_desc.rx_bits  = i_cmd.rx_bits;
    end
endmodule

// File: design/i2cms_queue.sv
// short command queue between intake and phase sequencer
module i2cms_queue #(
    parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cms_pkg::t_desc   i_desc,
    output logic               o_full,
    output logic               o_valid,
    output i2cms_pkg::t_desc   o_desc,
    input  logic               i_pop
);
    import i2cms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end
endmodule

// File: design/i2cms_back.sv
// phase sequencer: walks bus segments and registers one phase beat per cycle unless stalled
module i2cms_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  i2cms_pkg::t_desc   i_q_desc,
    output logic               o_q_pop,
    i2cms_phase_if.source      o_phase
);
    import i2cms_pkg::*;

    function automatic t_seg first_seg(input t_op op);
        t_seg seg;
        case (op)
            OP_START: seg = SEG_START;
            OP_PROBE: seg = SEG_START;
            OP_STOP:  seg = SEG_STOP;
            OP_SEND:  seg = SEG_SEND;
            OP_RECV:  seg = SEG_RECV;
            OP_ACK:   seg = SEG_ACKBIT;
            OP_NAK:   seg = SEG_ACKBIT;
            default:  seg = SEG_START;
        endcase
        return seg;
    endfunction

    t_seg               r_seg, n_seg, cur_seg;
    logic [STEP_W-1:0]  r_step, n_step, cur_step;
    logic               r_in_cmd, n_in_cmd;
    logic               r_scl, r_sda, r_drv;
    logic               n_scl, n_sda, n_drv;
    logic [HOLD_W-1:0]  ph_hold;
    logic               seg_end, cmd_last, chain;
    logic [STATUS_W-1:0] ph_status;
    logic [BYTE_W-1:0]  ph_rx;
    logic [2:0]         bit_k;
    logic [BYTE_W-1:0]  sh_byte;
    logic               advance;

    logic               r_o_valid;
    logic               r_o_scl, r_o_sda, r_o_en, r_o_last;
    logic [HOLD_W-1:0]  r_o_hold;
    logic [STATUS_W-1:0] r_o_status;
    logic [BYTE_W-1:0]  r_o_rx;

    assign cur_seg  = r_in_cmd ? r_seg : first_seg(i_q_desc.op);
    assign cur_step = r_in_cmd ? r_step : STEP_FIRST;
    assign advance  = i_q_valid && (!r_o_valid || o_phase.ready);
    assign o_q_pop  = advance && cmd_last;

    // phase levels, hold and end of segment
    always_comb begin
        bit_k   = cur_step[3:1];
        sh_byte = i_q_desc.tx_byte << bit_k;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        ph_hold = HOLD_NONE;
        seg_end = 1'b0;
        case (cur_seg)
            SEG_START: begin
                if (cur_step == STEP_FIRST) begin
                    n_sda   = 1'b1;
                    n_drv   = 1'b1;
                    n_scl   = 1'b1;
                    ph_hold = i_q_desc.bus_free ? HOLD_SETUP : HOLD_NONE;
                    seg_end = !i_q_desc.bus_free;
                end else if (cur_step == STEP_SECOND) begin
                    n_sda   = 1'b0;
                    ph_hold = HOLD_LONG;
                end else begin
                    n_scl   = 1'b0;
                    seg_end = 1'b1;
                end
            end
            SEG_STOP: begin
                if (cur_step == STEP_FIRST) begin
                    n_drv   = 1'b1;
                    n_sda   = 1'b0;
                    ph_hold = HOLD_MID;
                end else if (cur_step == STEP_SECOND) begin
                    n_scl   = 1'b1;
                    ph_hold = HOLD_LONG;
                end else begin
                    n_sda   = 1'b1;
                    seg_end = 1'b1;
                end
            end
            SEG_SEND: begin
                if (cur_step < STEP_ACK_LOW) begin
                    if (!cur_step[0]) begin
                        n_drv   = 1'b1;
                        n_sda   = sh_byte[BYTE_W-1];
                        n_scl   = (cur_step == STEP_FIRST) ? r_scl : 1'b0;
                        ph_hold = HOLD_SETUP;
                    end else begin
                        n_scl   = 1'b1;
                        ph_hold = HOLD_HIGH;
                    end
                end else if (cur_step == STEP_ACK_LOW) begin
                    n_drv   = 1'b0;
                    n_scl   = 1'b0;
                    ph_hold = HOLD_MID;
                end else if (cur_step == STEP_ACK_HIGH) begin
                    n_scl   = 1'b1;
                    ph_hold = HOLD_HIGH;
                end else begin
                    n_scl   = 1'b0;
                    seg_end = 1'b1;
                end
            end
            SEG_RECV: begin
                if (cur_step < STEP_ACK_LOW) begin
                    if (!cur_step[0]) begin
                        n_drv   = 1'b0;
                        n_scl   = (cur_step == STEP_FIRST) ? r_scl : 1'b0;
                        ph_hold = HOLD_RXLOW;
                    end else begin
                        n_scl   = 1'b1;
                        ph_hold = HOLD_MID;
                    end
                end else begin
                    n_scl   = 1'b0;
                    seg_end = 1'b1;
                end
            end
            SEG_ACKBIT: begin
                if (cur_step == STEP_FIRST) begin
                    n_sda   = (i_q_desc.op == OP_NAK);
                    n_drv   = 1'b1;
                    ph_hold = HOLD_MID;
                end else if (cur_step == STEP_SECOND) begin
                    n_scl   = 1'b1;
                    ph_hold = HOLD_HIGH;
                end else begin
                    n_scl   = 1'b0;
                    seg_end = 1'b1;
                end
            end
            default: begin
                seg_end = 1'b1;
            end
        endcase
    end

    // command completion, status and received byte
    always_comb begin
        chain     = (i_q_desc.op == OP_PROBE) &&
                    ((cur_seg == SEG_START) || (cur_seg == SEG_SEND));
        cmd_last  = seg_end && !chain;
        ph_status = ST_OK;
        ph_rx     = '0;
        if (cmd_last) begin
            case (i_q_desc.op)
                OP_START: ph_status = i_q_desc.bus_free ? ST_OK : ST_BUSY;
                OP_SEND:  ph_status = i_q_desc.nak ? ST_NO_ACK : ST_OK;
                OP_PROBE: begin
                    if (!i_q_desc.bus_free) begin
                        ph_status = ST_BUSY;
                    end else if (i_q_desc.nak) begin
                        ph_status = ST_NO_ACK;
                    end else begin
                        ph_status = ST_OK;
                    end
                end
                OP_RECV:  ph_rx = i_q_desc.rx_bits;
                default:  ph_status = ST_OK;
            endcase
        end
    end

    // next segment and step
    always_comb begin
        n_seg    = cur_seg;
        n_step   = cur_step + 1'b1;
        n_in_cmd = 1'b1;
        if (seg_end) begin
            n_step = STEP_FIRST;
            if (chain && (cur_seg == SEG_START)) begin
                n_seg = i_q_desc.bus_free ? SEG_SEND : SEG_STOP;
            end else if (chain) begin
                n_seg = SEG_STOP;
            end else begin
                n_in_cmd = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= SEG_START;
            r_step    <= STEP_FIRST;
            r_in_cmd  <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drv     <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_seg     <= n_seg;
                r_step    <= n_step;
                r_in_cmd  <= n_in_cmd;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_drv     <= n_drv;
                r_o_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_scl    <= n_scl;
            r_o_sda    <= n_sda;
            r_o_en     <= n_drv;
            r_o_hold   <= ph_hold;
            r_o_status <= ph_status;
            r_o_rx     <= ph_rx;
            r_o_last   <= cmd_last;
        end
    end

    assign o_phase.valid      = r_o_valid;
    assign o_phase.scl_level  = r_o_scl;
    assign o_phase.sda_level  = r_o_sda;
    assign o_phase.sda_enable = r_o_en;
    assign o_phase.hold_ticks = r_o_hold;
    assign o_phase.status     = r_o_status;
    assign o_phase.rx_data    = r_o_rx;
    assign o_phase.last       = r_o_last;
endmodule
